### rtl/core/slt_pkg.sv
package slt_pkg;

	// Default sizes of the table.
	localparam int DEPTH_DEFAULT      = 16;
	localparam int DATA_WIDTH_DEFAULT = 32;

	// Fixed widths of the request and result fields.
	localparam int KIND_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	// Packed stream widths, padded to whole bytes.
	localparam int IN_FIELDS_W  = KIND_W + VALUE_W + POS_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = STATUS_W + 1 + OCC_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_SEARCH = 2'd1,
		KIND_DELETE = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Command broadcast from the top level to every cell of the chain.
	typedef struct packed {
		logic             insert;
		logic             remove;
		logic [POS_W-1:0] position;
	} cell_ctrl_t;

endpackage

### rtl/core/slt_cell.sv
// One slot of the sorted table. It compares its entry with the request key and
// either keeps its entry, takes the key, or takes a neighbor's entry.
module slt_cell #(
	parameter int INDEX      = 0,
	parameter int DATA_WIDTH = slt_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  slt_pkg::cell_ctrl_t    ctrl,
	input  logic [DATA_WIDTH-1:0]  key,
	input  logic [DATA_WIDTH-1:0]  left_entry,
	input  logic                   left_occ,
	input  logic                   left_lt,
	input  logic [DATA_WIDTH-1:0]  right_entry,
	input  logic                   right_occ,
	output logic [DATA_WIDTH-1:0]  entry,
	output logic                   occ,
	output logic                   lt,
	output logic                   match
);

	// One-based position of this slot, one bit wider than a position field.
	localparam logic [slt_pkg::POS_W:0] ORDINAL = (slt_pkg::POS_W + 1)'(INDEX + 1);

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  occ_q;
	logic                  shift_down;

	assign lt    = occ_q && ($signed(entry_q) < $signed(key));
	assign match = occ_q && (entry_q == key);
	assign entry = entry_q;
	assign occ   = occ_q;

	// Slots at or past the removed position pull from their right neighbor.
	assign shift_down = ORDINAL >= {1'b0, ctrl.position};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.insert) begin
			occ_q <= occ_q | left_occ;
		end else if (ctrl.remove && shift_down) begin
			occ_q <= right_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert && !lt) begin
			entry_q <= left_lt ? key : left_entry;
		end else if (ctrl.remove && shift_down) begin
			entry_q <= right_entry;
		end
	end

endmodule

### rtl/core/sorted_list_table_unit.sv
// Channel  Direction  Width  Contents (lowest bit first)
// s_*      in         48     kind[1:0], value[33:2], position[41:34], zero pad
// m_*      out        8      status[1:0], found[2], occupancy[7:3]
//
// Every request is finished in the cycle it is accepted: all cells compare the
// key at once and shift in the same clock edge, and the result lands in the
// output register at that same edge. A request is taken whenever that register
// is empty or being drained, so one request per cycle is sustained while the
// result side keeps up. Reset empties the table at once; no clearing pass.
module sorted_list_table_unit #(
	parameter int DEPTH      = slt_pkg::DEPTH_DEFAULT,
	parameter int DATA_WIDTH = slt_pkg::DATA_WIDTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// kind[1:0], value[33:2], position[41:34], zero pad above.
	input  logic [slt_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// status[1:0], found[2], occupancy[7:3].
	output logic [slt_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	// The count must hold DEPTH itself; compares against a position are done
	// at the wider of the two widths.
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > slt_pkg::POS_W) ? CNT_W : slt_pkg::POS_W;

	logic [slt_pkg::KIND_W-1:0]  kind;
	logic [slt_pkg::VALUE_W-1:0] value;
	logic [slt_pkg::POS_W-1:0]   position;
	logic [DATA_WIDTH-1:0]       key;

	logic                        accept;
	logic                        full;
	logic                        pos_bad;
	slt_pkg::cell_ctrl_t         ctrl;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            count_d;
	slt_pkg::status_t            status_d;
	logic                        found_d;

	logic                        out_valid_q;
	logic [slt_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic [DATA_WIDTH-1:0] cell_entry [DEPTH];
	logic [DEPTH-1:0]      cell_occ;
	logic [DEPTH-1:0]      cell_lt;
	logic [DEPTH-1:0]      cell_match;

	assign kind     = s_tdata[slt_pkg::KIND_W-1:0];
	assign value    = s_tdata[slt_pkg::KIND_W +: slt_pkg::VALUE_W];
	assign position = s_tdata[slt_pkg::KIND_W + slt_pkg::VALUE_W +: slt_pkg::POS_W];

	// The value is taken at the table's data width, sign-extended if wider.
	generate
		if (DATA_WIDTH <= slt_pkg::VALUE_W) begin : g_key_trunc
			assign key = value[DATA_WIDTH-1:0];
		end else begin : g_key_ext
			assign key = {{(DATA_WIDTH - slt_pkg::VALUE_W){value[slt_pkg::VALUE_W-1]}}, value};
		end
	endgenerate

	// The output register frees the input side as soon as it is taken.
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign full    = count_q == CNT_W'(DEPTH);
	assign pos_bad = (position == '0) || (CMP_W'(position) > CMP_W'(count_q));

	// Decode the request. A full insert or an out-of-range delete leaves the
	// cells alone and only reports a status; the unused kind changes nothing.
	always_comb begin
		ctrl.insert   = 1'b0;
		ctrl.remove   = 1'b0;
		ctrl.position = position;
		count_d       = count_q;
		status_d      = slt_pkg::STATUS_OK;
		found_d       = 1'b0;
		unique case (kind)
			slt_pkg::KIND_INSERT: begin
				if (full) begin
					status_d = slt_pkg::STATUS_FULL;
				end else begin
					ctrl.insert = accept;
					count_d     = count_q + CNT_W'(1);
				end
			end
			slt_pkg::KIND_SEARCH: begin
				found_d = |cell_match;
			end
			slt_pkg::KIND_DELETE: begin
				if (pos_bad) begin
					status_d = slt_pkg::STATUS_RANGE;
				end else begin
					ctrl.remove = accept;
					count_d     = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// The chain: each cell sees its left neighbor for inserts and its right
	// neighbor for deletes. The first cell treats its left edge as an occupied
	// entry that is less than any key; the last cell pulls in an empty slot.
	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			logic [DATA_WIDTH-1:0] l_entry;
			logic                  l_occ;
			logic                  l_lt;
			logic [DATA_WIDTH-1:0] r_entry;
			logic                  r_occ;

			if (i == 0) begin : g_left_edge
				assign l_entry = key;
				assign l_occ   = 1'b1;
				assign l_lt    = 1'b1;
			end else begin : g_left
				assign l_entry = cell_entry[i-1];
				assign l_occ   = cell_occ[i-1];
				assign l_lt    = cell_lt[i-1];
			end

			if (i == DEPTH - 1) begin : g_right_edge
				assign r_entry = key;
				assign r_occ   = 1'b0;
			end else begin : g_right
				assign r_entry = cell_entry[i+1];
				assign r_occ   = cell_occ[i+1];
			end

			slt_cell #(
				.INDEX      (i),
				.DATA_WIDTH (DATA_WIDTH)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.key         (key),
				.left_entry  (l_entry),
				.left_occ    (l_occ),
				.left_lt     (l_lt),
				.right_entry (r_entry),
				.right_occ   (r_occ),
				.entry       (cell_entry[i]),
				.occ         (cell_occ[i]),
				.lt          (cell_lt[i]),
				.match       (cell_match[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Occupancy is reported modulo 32.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= slt_pkg::OUT_TDATA_W'({slt_pkg::OCC_W'(count_d), found_d, status_d});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
